// File: hdl/nqse_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers for the N-Queens enumerator.
// No dependencies; nqse_out_if, nqse_cell and the top module use this package.
package nqse_pkg;

  localparam int COL_W   = 3;
  localparam int MASK_W  = 8;
  localparam int SIZE_W  = 4;
  localparam int DEPTH_W = 4;
  localparam int PLACE_W = 24;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic active;
    logic resume;
  } cell_ctrl_t;

  // Attack masks handed from one row cell to the row below.
  typedef struct packed {
    logic  load;
    mask_t col_m;
    mask_t diag_l;
    mask_t diag_r;
  } handoff_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic col_t lowest_bit(input mask_t m);
    col_t idx;
    idx = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = col_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: hdl/nqse_in_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying the restart flag.
// Depends on nothing.
interface nqse_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// File: hdl/nqse_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying found and placement.
// Depends on nqse_pkg for the placement width.
interface nqse_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [nqse_pkg::PLACE_W-1:0] placement;

  modport source (output valid, output found, output placement, input ready);
  modport sink   (input valid, input found, input placement, output ready);
endinterface

// File: hdl/nqse_cell.sv
`timescale 1ns / 1ps
// One board row: holds its queen column and the attack masks from above,
// finds the next free column and hands updated masks to the row below. Uses nqse_pkg.
module nqse_cell (
  input  logic                 clk,
  input  nqse_pkg::cell_ctrl_t ctrl,
  input  nqse_pkg::mask_t      size_mask,
  input  nqse_pkg::handoff_t   prev,
  output nqse_pkg::handoff_t   next,
  output logic                 hit,
  output nqse_pkg::col_t       col
);
  import nqse_pkg::*;

  mask_t  col_m_r, diag_l_r, diag_r_r;
  col_t   col_r;
  size_t  start;
  mask_t  avail;
  col_t   pick;
  mask_t  pick_bit;

  always_comb begin
    // resume tries the column after the current queen, otherwise start at zero
    start    = ctrl.resume ? (size_t'(col_r) + size_t'(1)) : '0;
    avail    = ~(col_m_r | diag_l_r | diag_r_r) & size_mask & ({MASK_W{1'b1}} << start);
    pick     = lowest_bit(avail);
    pick_bit = mask_t'(1) << pick;
    hit      = ctrl.active && (|avail);

    next.load   = hit;
    next.col_m  = col_m_r | pick_bit;
    next.diag_l = (diag_l_r | pick_bit) << 1;
    next.diag_r = (diag_r_r | pick_bit) >> 1;
  end

  always_ff @(posedge clk) begin
    if (prev.load) begin
      col_m_r  <= prev.col_m;
      diag_l_r <= prev.diag_l;
      diag_r_r <= prev.diag_r;
    end
    if (hit) begin
      col_r <= pick;
    end
  end

  assign col = col_r;

endmodule

// File: hdl/n_queens_solution_enumerator.sv
`timescale 1ns / 1ps
// N-Queens enumerator: each request word returns the next solution in depth-first
// order (rows top down, columns ascending), or found=0 once all are given; restart=1
// or a write of board_size begins again. A request is taken in IDLE and answered from
// EMIT; in SEARCH each step places a queen in the active row cell or backtracks one
// row, so latency depends on the board and on where the previous solution left off.
// One request is searched at a time; a finished result waits in the output register
// while the next request is taken. Depends on nqse_pkg, nqse_in_if, nqse_out_if, nqse_cell.
module n_queens_solution_enumerator #(
  parameter int MAX_SIZE = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [nqse_pkg::SIZE_W-1:0] cfg_wdata,
  nqse_in_if.sink                in_ch,
  nqse_out_if.source             out_ch
);
  import nqse_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  size_t  size_r, size_nxt;
  depth_t depth_r, depth_nxt;
  logic   resume_r, resume_nxt;
  logic   started_r, started_nxt;
  logic   exhausted_r, exhausted_nxt;
  logic   res_found_r, res_found_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_found_r, out_found_nxt;
  logic [PLACE_W-1:0] out_place_r, out_place_nxt;

  size_t  n;
  mask_t  size_mask;
  logic   accept;
  logic   fresh;
  logic   any_hit;
  logic   st_eff, ex_eff;
  logic [PLACE_W-1:0] packed_cols;

  cell_ctrl_t ctrl   [MAX_SIZE];
  handoff_t   link   [MAX_SIZE+1];
  logic [MAX_SIZE-1:0] hits;
  col_t       cols   [MAX_SIZE];

  // clamp board size into 1..MAX_SIZE
  always_comb begin
    if (size_r == '0) begin
      n = size_t'(1);
    end else if (size_r > size_t'(MAX_SIZE)) begin
      n = size_t'(MAX_SIZE);
    end else begin
      n = size_r;
    end
  end

  assign size_mask = ~({MASK_W{1'b1}} << n);
  assign accept    = in_ch.valid && in_ch.ready;
  assign any_hit   = |hits;

  // row 0 starts from empty masks
  assign link[0].load   = fresh;
  assign link[0].col_m  = '0;
  assign link[0].diag_l = '0;
  assign link[0].diag_r = '0;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_SIZE; gi++) begin : g_row
      assign ctrl[gi].active = (state_r == ST_SEARCH) && (depth_r == depth_t'(gi));
      assign ctrl[gi].resume = resume_r;

      nqse_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl[gi]),
        .size_mask (size_mask),
        .prev      (link[gi]),
        .next      (link[gi+1]),
        .hit       (hits[gi]),
        .col       (cols[gi])
      );
    end
  endgenerate

  // rows past the board read zero
  always_comb begin
    packed_cols = '0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      if (size_t'(i) < n) begin
        packed_cols[COL_W*i +: COL_W] = cols[i];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    depth_nxt     = depth_r;
    resume_nxt    = resume_r;
    started_nxt   = started_r;
    exhausted_nxt = exhausted_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_place_nxt = out_place_r;
    fresh         = 1'b0;
    st_eff        = in_ch.restart ? 1'b0 : started_r;
    ex_eff        = in_ch.restart ? 1'b0 : exhausted_r;

    // drop the result word once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      size_nxt      = cfg_wdata;
      depth_nxt     = '0;
      started_nxt   = 1'b0;
      exhausted_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          started_nxt   = st_eff;
          exhausted_nxt = ex_eff;
          if (in_ch.restart) begin
            depth_nxt = '0;
          end
          if (ex_eff) begin
            res_found_nxt = 1'b0;
            state_nxt     = ST_EMIT;
          end else if (!st_eff) begin
            fresh       = 1'b1;
            started_nxt = 1'b1;
            depth_nxt   = '0;
            resume_nxt  = 1'b0;
            state_nxt   = ST_SEARCH;
          end else if (depth_r != depth_t'(n)) begin
            exhausted_nxt = 1'b1;
            res_found_nxt = 1'b0;
            state_nxt     = ST_EMIT;
          end else begin
            // resume from the last row of the previous solution
            depth_nxt  = depth_r - depth_t'(1);
            resume_nxt = 1'b1;
            state_nxt  = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (any_hit) begin
          depth_nxt  = depth_r + depth_t'(1);
          resume_nxt = 1'b0;
          if ((depth_r + depth_t'(1)) == depth_t'(n)) begin
            res_found_nxt = 1'b1;
            state_nxt     = ST_EMIT;
          end
        end else if (depth_r == '0) begin
          exhausted_nxt = 1'b1;
          res_found_nxt = 1'b0;
          state_nxt     = ST_EMIT;
        end else begin
          // backtrack one row
          depth_nxt  = depth_r - depth_t'(1);
          resume_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_place_nxt = res_found_r ? packed_cols : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= size_t'(4);
      depth_r     <= '0;
      resume_r    <= 1'b0;
      started_r   <= 1'b0;
      exhausted_r <= 1'b0;
      res_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      depth_r     <= depth_nxt;
      resume_r    <= resume_nxt;
      started_r   <= started_nxt;
      exhausted_r <= exhausted_nxt;
      res_found_r <= res_found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_place_r <= out_place_nxt;
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.placement = out_place_r;

endmodule
